// ===== rtl/bmcs_pkg.sv =====
// Package for the bucketed min-count sketch: sizes, register indexes, types.
// No dependencies.
package bmcs_pkg;
	localparam int NUM_BUCKETS = 1024;
	localparam int COUNTERS_PER_BUCKET = 8;
	localparam int MAX_OPTIONS = 56;
	localparam int MASK_WORDS = 7;
	localparam int BUCKET_W = $clog2(NUM_BUCKETS);
	localparam int CTR_W = 32;
	localparam int HASH_LOW_BITS = 10;
	localparam int QUOT_W = 22;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_OPTION_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_WORD_0 = 3'd1;
	localparam logic OP_INC = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic [CTR_W-1:0] EST_EMPTY = '1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_MOD   = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CALC  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;
endpackage

// ===== rtl/bmcs_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module bmcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bucketed_min_count_sketch.sv =====
// Top level of the bucketed min-count sketch: config registers, sequencer, counters.
// Depends on bmcs_pkg and bmcs_ram (eight banks, one per counter of a bucket).
//
//  channel | signals                          | direction
//  input   | in_valid in_stall op key_hash    | in (stall out)
//  output  | out_valid out_stall estimate     | out (stall in)
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in (ready out)
//
// Each item passes through the accepting idle state, the bit-serial option modulo,
// the mask select, the compare/write-back and the output state; no new item is
// accepted until its result has been taken. After reset a clearing pass writes
// zero to all 1024 rows, during which no item is accepted. Config writes are
// always taken.
// A stalled result holds the sequencer until it is taken.
module bucketed_min_count_sketch (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] key_hash,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] estimate,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [bmcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int BW = bmcs_pkg::BUCKET_W;
	localparam int NC = bmcs_pkg::COUNTERS_PER_BUCKET;
	localparam int CW = bmcs_pkg::CTR_W;
	localparam int QW = bmcs_pkg::QUOT_W;

	logic [5:0]  opt_cnt_q;
	logic [63:0] masks_q [bmcs_pkg::MASK_WORDS];
	bmcs_pkg::state_t state_q;
	logic [BW-1:0] clr_q, bucket_q;
	logic          op_q;
	logic [QW-1:0] quot_q;
	logic [5:0]    rem_q, div_q;
	logic [4:0]    bit_q;
	logic [NC-1:0] mask_q;
	logic [CW-1:0] est_q;
	logic [CW-1:0] rd [NC];
	logic [CW-1:0] wd [NC];
	logic [NC-1:0] we;
	logic [5:0]    opt;
	logic [6:0]    trial;
	logic [CW-1:0] mn;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != bmcs_pkg::ST_IDLE);
	assign out_valid = (state_q == bmcs_pkg::ST_OUT);
	assign estimate = est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_cnt_q <= 6'd1;
			for (int i = 0; i < bmcs_pkg::MASK_WORDS; i++) masks_q[i] <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == bmcs_pkg::REG_OPTION_COUNT) opt_cnt_q <= cfg_data[5:0];
			else if (cfg_index <= 3'(bmcs_pkg::MASK_WORDS))
				masks_q[cfg_index - bmcs_pkg::REG_MASK_WORD_0] <= cfg_data;
		end
	end

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quot_q[QW-1]} - {1'b0, div_q};
	assign opt = rem_q;

	always_comb begin
		mn = bmcs_pkg::EST_EMPTY;
		for (int c = 0; c < NC; c++) begin
			if (mask_q[c] && rd[c] < mn) mn = rd[c];
			wd[c] = (state_q == bmcs_pkg::ST_CLEAR) ? '0 : rd[c] + 32'd1;
			we[c] = (state_q == bmcs_pkg::ST_CLEAR) ||
				(state_q == bmcs_pkg::ST_CALC && op_q == bmcs_pkg::OP_INC && mask_q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmcs_pkg::ST_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				bmcs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(bmcs_pkg::NUM_BUCKETS - 1)) state_q <= bmcs_pkg::ST_IDLE;
				end
				bmcs_pkg::ST_IDLE: if (in_valid) state_q <= bmcs_pkg::ST_MOD;
				bmcs_pkg::ST_MOD: if (bit_q == 5'd0) state_q <= bmcs_pkg::ST_READ;
				bmcs_pkg::ST_READ: state_q <= bmcs_pkg::ST_CALC;
				bmcs_pkg::ST_CALC: state_q <= bmcs_pkg::ST_OUT;
				bmcs_pkg::ST_OUT: if (!out_stall) state_q <= bmcs_pkg::ST_IDLE;
				default: state_q <= bmcs_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bmcs_pkg::ST_IDLE: begin
				op_q <= op;
				bucket_q <= key_hash[BW-1:0];
				quot_q <= key_hash[31:bmcs_pkg::HASH_LOW_BITS];
				rem_q <= '0;
				bit_q <= 5'(QW - 1);
				div_q <= (opt_cnt_q <= 6'd1) ? 6'd0 : opt_cnt_q - 6'd1;
			end
			bmcs_pkg::ST_MOD: begin
				quot_q <= quot_q << 1;
				bit_q <= bit_q - 5'd1;
				if (div_q == 6'd0) rem_q <= '0;
				else if (!trial[6]) rem_q <= trial[5:0];
				else rem_q <= {rem_q[4:0], quot_q[QW-1]};
			end
			bmcs_pkg::ST_READ: begin
				if (opt >= 6'(bmcs_pkg::MAX_OPTIONS)) mask_q <= '0;
				else mask_q <= masks_q[opt[5:3]][{opt[2:0], 3'b000} +: 8];
			end
			bmcs_pkg::ST_CALC: est_q <= (op_q == bmcs_pkg::OP_QUERY) ? mn : '0;
			default: ;
		endcase
	end

	for (genvar c = 0; c < NC; c++) begin : g_bank
		bmcs_ram #(.WIDTH(CW), .DEPTH(bmcs_pkg::NUM_BUCKETS)) u_bank (
			.clk(clk), .we(we[c]),
			.waddr(state_q == bmcs_pkg::ST_CLEAR ? clr_q : bucket_q),
			.wdata(wd[c]), .raddr(bucket_q), .rdata(rd[c])
		);
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(estimate))
		else $error("result dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_incr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_q == bmcs_pkg::OP_INC |-> estimate == '0)
		else $error("increment estimate not zero");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmcs_pkg::ST_READ && div_q != 6'd0 |-> rem_q < div_q)
		else $error("modulo remainder out of range");
`endif
endmodule
